[rtl/core/hrlvs_pkg.sv]
// Shared constants, types and command structures for the hybrid reuse/LRU victim selector.
package hrlvs_pkg;
  localparam int NUM_SETS     = 2048;
  localparam int NUM_WAYS     = 16;
  localparam int PRED_ENTRIES = 4096;
  localparam int SET_W        = $clog2(NUM_SETS);
  localparam int WAY_W        = $clog2(NUM_WAYS);
  localparam int PRED_W       = $clog2(PRED_ENTRIES);
  localparam int LINE_AW      = SET_W + WAY_W;
  localparam int CNT_W        = 32;
  localparam int STAMP_W      = 32;
  localparam int REUSE_W      = 3;
  localparam int WIN_W        = 16;
  localparam int THR_W        = 9;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int PC_W         = 48;

  localparam logic [REUSE_W-1:0] REUSE_MAX  = 3'd7;
  localparam logic [REUSE_W-1:0] CAND_LIMIT = 3'd2;
  localparam logic [WIN_W-1:0]   WIN_RESET  = 16'd128;
  localparam logic [THR_W-1:0]   THR_RESET  = 9'd210;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 8'd1;

  localparam logic KIND_VICTIM = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  typedef struct packed {
    logic                load;
    logic                clr_en;
    logic [LINE_AW-1:0]  clr_addr;
    logic                set_calc;
    logic                strm_calc;
    logic                scan_issue;
    logic                upd_rd;
    logic                upd_old;
    logic                age_issue;
    logic                out_load;
    logic [WAY_W-1:0]    way_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic kind;
  } dp_status_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + 1'b1;
  endfunction
endpackage

[rtl/core/hrlvs_datapath.sv]
// Datapath: line, set and predictor memories, streaming test, victim scan and LRU aging.
module hrlvs_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  hrlvs_pkg::dp_cmd_t                   cmd,
  output hrlvs_pkg::dp_status_t                status,
  input  logic                                 in_kind,
  input  logic [hrlvs_pkg::SET_W-1:0]          in_set_index,
  input  logic [hrlvs_pkg::WAY_W-1:0]          in_way,
  input  logic [hrlvs_pkg::PC_W-1:0]           in_pc,
  input  logic                                 in_hit,
  input  logic                                 cfg_valid,
  input  logic                                 cfg_ready,
  input  logic [hrlvs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hrlvs_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [hrlvs_pkg::WAY_W-1:0]          out_victim_way,
  output logic                                 out_streaming
);
  import hrlvs_pkg::*;

  localparam int LINE_DW = PRED_W + STAMP_W + WAY_W;
  localparam int PROD_W  = THR_W + CNT_W;

  logic [LINE_DW-1:0]   line_mem [2**LINE_AW];
  logic [2*CNT_W-1:0]   set_mem  [2**SET_W];
  logic [REUSE_W-1:0]   reuse_mem[2**PRED_W];

  logic [WIN_W-1:0]     window_r;
  logic [THR_W-1:0]     thr_r;
  logic                 kind_r;
  logic [SET_W-1:0]     set_r;
  logic [WAY_W-1:0]     way_r;
  logic [PRED_W-1:0]    pi_r;
  logic                 hit_r;

  logic [LINE_DW-1:0]   line_q;
  logic [2*CNT_W-1:0]   set_q;
  logic [REUSE_W-1:0]   reuse_q;

  logic [CNT_W-1:0]     acc_r, miss_r;
  logic [PROD_W-1:0]    prod_r;
  logic                 win_hit_r;
  logic [WAY_W-1:0]     old_rank_r;

  logic                 v1_r, v2_r, a1_r;
  logic [WAY_W-1:0]     w1_r, w2_r, aw1_r;
  logic [WAY_W-1:0]     rank2_r;
  logic [STAMP_W-1:0]   stamp2_r;

  logic [WAY_W-1:0]     max_rank_r, lru_way_r, cand_way_r;
  logic                 any_cand_r;
  logic [STAMP_W-1:0]   oldest_r;

  logic [LINE_AW-1:0]   line_raddr;
  logic [PRED_W-1:0]    reuse_raddr;
  logic                 line_we, set_we, reuse_we;
  logic [LINE_AW-1:0]   line_waddr;
  logic [LINE_DW-1:0]   line_wdata;
  logic [SET_W-1:0]     set_waddr;
  logic [2*CNT_W-1:0]   set_wdata;
  logic [PRED_W-1:0]    reuse_waddr;
  logic [REUSE_W-1:0]   reuse_wdata;
  logic [CNT_W-1:0]     acc_in, miss_in;
  logic [WAY_W-1:0]     q_rank;
  logic [WAY_W-1:0]     new_rank;
  logic                 streaming;

  assign status.kind = kind_r;
  assign acc_in      = set_q[CNT_W-1:0];
  assign miss_in     = set_q[2*CNT_W-1:CNT_W];
  assign q_rank      = line_q[WAY_W-1:0];
  assign line_raddr  = cmd.upd_rd ? {set_r, way_r} : {set_r, cmd.way_sel};
  assign reuse_raddr = cmd.upd_rd ? pi_r : line_q[LINE_DW-1 -: PRED_W];
  assign streaming   = win_hit_r && ({miss_r, 8'd0} > {1'b0, prod_r});
  assign new_rank    = (q_rank < old_rank_r) ? q_rank + 1'b1 : q_rank;

  always_comb begin
    line_we     = 1'b0;
    line_waddr  = {set_r, aw1_r};
    line_wdata  = (aw1_r == way_r) ? {pi_r, acc_r, {WAY_W{1'b0}}}
                                   : {line_q[LINE_DW-1:WAY_W], new_rank};
    set_we      = 1'b0;
    set_waddr   = set_r;
    set_wdata   = (kind_r == KIND_VICTIM) ? {miss_in, sat_inc(acc_in)}
                                          : {(hit_r ? miss_in : sat_inc(miss_in)), acc_in};
    reuse_we    = 1'b0;
    reuse_waddr = pi_r;
    if (hit_r) begin
      reuse_wdata = (reuse_q < REUSE_MAX) ? reuse_q + 1'b1 : reuse_q;
    end else begin
      reuse_wdata = (reuse_q != '0) ? reuse_q - 1'b1 : reuse_q;
    end
    if (cmd.clr_en) begin
      line_we     = 1'b1;
      line_waddr  = cmd.clr_addr;
      line_wdata  = {{(PRED_W + STAMP_W){1'b0}}, cmd.clr_addr[WAY_W-1:0]};
      set_we      = 1'b1;
      set_waddr   = cmd.clr_addr[SET_W-1:0];
      set_wdata   = '0;
      reuse_we    = 1'b1;
      reuse_waddr = cmd.clr_addr[PRED_W-1:0];
      reuse_wdata = '0;
    end else begin
      line_we  = a1_r;
      set_we   = cmd.set_calc;
      reuse_we = cmd.upd_old;
    end
  end

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[line_waddr] <= line_wdata;
    end
    if (set_we) begin
      set_mem[set_waddr] <= set_wdata;
    end
    if (reuse_we) begin
      reuse_mem[reuse_waddr] <= reuse_wdata;
    end
    line_q  <= line_mem[line_raddr];
    set_q   <= set_mem[set_r];
    reuse_q <= reuse_mem[reuse_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WIN_RESET;
      thr_r    <= THR_RESET;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      a1_r     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_IDX_WINDOW) begin
          window_r <= cfg_data;
        end else if (cfg_index == CFG_IDX_THRESHOLD) begin
          thr_r <= cfg_data[THR_W-1:0];
        end
      end
      v1_r <= cmd.scan_issue;
      v2_r <= v1_r;
      a1_r <= cmd.age_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      set_r  <= in_set_index;
      way_r  <= in_way;
      pi_r   <= in_pc[PRED_W-1:0];
      hit_r  <= in_hit;
    end
    if (cmd.set_calc) begin
      acc_r  <= (kind_r == KIND_VICTIM) ? sat_inc(acc_in) : acc_in;
      miss_r <= miss_in;
    end
    if (cmd.upd_old) begin
      old_rank_r <= q_rank;
    end
    w1_r     <= cmd.way_sel;
    w2_r     <= w1_r;
    aw1_r    <= cmd.way_sel;
    rank2_r  <= q_rank;
    stamp2_r <= line_q[WAY_W +: STAMP_W];
    if (cmd.strm_calc) begin
      prod_r     <= PROD_W'(thr_r) * PROD_W'(acc_r);
      win_hit_r  <= acc_r > CNT_W'(window_r);
      max_rank_r <= '0;
      lru_way_r  <= '0;
      cand_way_r <= '0;
      any_cand_r <= 1'b0;
      oldest_r   <= '0;
    end else if (v2_r) begin
      if (rank2_r > max_rank_r) begin
        max_rank_r <= rank2_r;
        lru_way_r  <= w2_r;
      end
      if (reuse_q <= CAND_LIMIT) begin
        any_cand_r <= 1'b1;
        if (stamp2_r <= oldest_r || oldest_r == '0) begin
          oldest_r   <= stamp2_r;
          cand_way_r <= w2_r;
        end
      end
    end
    if (cmd.out_load) begin
      out_victim_way <= (streaming || !any_cand_r) ? lru_way_r : cand_way_r;
      out_streaming  <= streaming;
    end
  end
endmodule

[rtl/core/hrlvs_ctrl.sv]
// Controller: clearing pass, handshakes and sequencing of victim requests and updates.
module hrlvs_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output hrlvs_pkg::dp_cmd_t      cmd,
  input  hrlvs_pkg::dp_status_t   status
);
  import hrlvs_pkg::*;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SETRD, S_SETCALC, S_STRM, S_VSCAN, S_VDRAIN, S_VOUT,
    S_UOLD, S_USCAN, S_UDRAIN
  } state_t;

  state_t             state_r;
  logic [LINE_AW-1:0] cnt_r;
  logic               out_valid_r;
  logic               out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    cmd            = '0;
    cmd.clr_addr   = cnt_r;
    cmd.way_sel    = cnt_r[WAY_W-1:0];
    case (state_r)
      S_CLR:     cmd.clr_en = 1'b1;
      S_IDLE:    cmd.load = in_valid;
      S_SETCALC: begin
        cmd.set_calc = 1'b1;
        cmd.upd_rd   = (status.kind == KIND_UPDATE);
      end
      S_STRM:    cmd.strm_calc = 1'b1;
      S_VSCAN:   cmd.scan_issue = 1'b1;
      S_VOUT:    cmd.out_load = out_free;
      S_UOLD:    cmd.upd_old = 1'b1;
      S_USCAN:   cmd.age_issue = 1'b1;
      default:   cmd.load = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_VOUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == '1) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_SETRD;
          end
        end
        S_SETRD:   state_r <= S_SETCALC;
        S_SETCALC: begin
          cnt_r   <= '0;
          state_r <= (status.kind == KIND_UPDATE) ? S_UOLD : S_STRM;
        end
        S_STRM:    state_r <= S_VSCAN;
        S_VSCAN: begin
          if (cnt_r[WAY_W-1:0] == '1) begin
            cnt_r   <= '0;
            state_r <= S_VDRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_VDRAIN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r[0]) begin
            state_r <= S_VOUT;
          end
        end
        S_VOUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        S_UOLD:    state_r <= S_USCAN;
        S_USCAN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r[WAY_W-1:0] == '1) begin
            state_r <= S_UDRAIN;
          end
        end
        S_UDRAIN:  state_r <= S_IDLE;
        default:   state_r <= S_IDLE;
      endcase
    end
  end
endmodule

[rtl/core/hybrid_reuse_lru_victim_select_top.sv]
// Top level of the hybrid reuse-predictor/LRU victim selector.
// Input beats carry a victim request (kind 0) or a replacement update (kind 1)
// for one cache set. A victim request returns one output beat with the chosen
// way and the streaming flag; an update returns nothing.
// A victim request passes from acceptance to output valid through the set
// counter read and write, the streaming product, the way scan through the
// single line memory port, the predictor lookup pipeline and the load of
// the output register.
// An update handles set counters, predictor counter, then read-modify-write
// passes over every way on the line memory to age the set.
// One item is processed at a time; the next is accepted once the current one
// has finished, even while a result beat still waits in the output register.
// If the receiver stalls, a finished victim request waits until the output
// register is free, and no further input is accepted meanwhile.
// After reset a clearing pass over all addresses initializes all memories;
// in_ready stays low during it, while configuration writes are always taken.
module hybrid_reuse_lru_victim_select_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_kind,
  input  logic [hrlvs_pkg::SET_W-1:0]          in_set_index,
  input  logic [hrlvs_pkg::WAY_W-1:0]          in_way,
  input  logic [hrlvs_pkg::PC_W-1:0]           in_pc,
  input  logic                                 in_hit,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [hrlvs_pkg::WAY_W-1:0]          out_victim_way,
  output logic                                 out_streaming,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [hrlvs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hrlvs_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import hrlvs_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  hrlvs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  hrlvs_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_kind        (in_kind),
    .in_set_index   (in_set_index),
    .in_way         (in_way),
    .in_pc          (in_pc),
    .in_hit         (in_hit),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_victim_way (out_victim_way),
    .out_streaming  (out_streaming)
  );
endmodule
